### sv/pmpf_pkg.sv
// Shared types, constants and helpers for the PS/2 mouse packet FIFO.
// Used by pmpf_ctrl and ps2_mouse_packet_fifo; depends on nothing.
package pmpf_pkg;

  localparam int RING_DEPTH  = 4096;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int CNT_W       = $clog2(RING_DEPTH + 1);
  localparam int COUNT_OUT_W = 13;

  // Bit positions in the controller status byte and the first packet byte.
  localparam int STATUS_DATA_PRESENT = 0;
  localparam int STATUS_MOUSE_PORT   = 5;
  localparam int PKT_SYNC_BIT        = 3;

  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_READ    = 1'b1;

  typedef enum logic [2:0] {
    KIND_NO_DATA  = 3'd0,
    KIND_KEYBOARD = 3'd1,
    KIND_OOS_DROP = 3'd2,
    KIND_HELD     = 3'd3,
    KIND_PUSHED   = 3'd4,
    KIND_READ     = 3'd5,
    KIND_EMPTY    = 3'd6
  } kind_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic             from_mem;
    logic [7:0]       obyte;
    logic [CNT_W-1:0] count;
    logic [1:0]       dropped;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

### sv/pmpf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds its value while no read is issued. No dependencies.
module pmpf_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/pmpf_ctrl.sv
// Control sequencer: ring pointers, fill count, packet aligner and result build.
// Depends on pmpf_pkg; drives the ring RAM through a pmpf_pkg::mem_req_t.
module pmpf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               mode,
  input  logic [7:0]         ctrl_status,
  input  logic [7:0]         data_byte,
  input  logic               slot_free,
  output logic               in_stall,
  output pmpf_pkg::mem_req_t mem,
  output pmpf_pkg::res_t     res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_PUSH1,
    S_PUSH2
  } state_t;

  state_t                       state;
  logic [pmpf_pkg::PTR_W-1:0]   rp;
  logic [pmpf_pkg::PTR_W-1:0]   wp;
  logic [pmpf_pkg::CNT_W-1:0]   fill;
  logic [7:0]                   hold0;
  logic [7:0]                   hold1;
  logic [7:0]                   last_byte;
  logic [1:0]                   pos;
  logic [1:0]                   drop_cnt;

  logic accept;
  logic full;
  logic is_mouse;
  logic completes;
  logic push_now;
  logic [7:0] push_byte;

  assign in_stall  = (state != S_IDLE) || res.valid || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign full      = (fill >= pmpf_pkg::CNT_W'(pmpf_pkg::RING_DEPTH));
  assign is_mouse  = (mode == pmpf_pkg::MODE_ARRIVAL)
                     && ctrl_status[pmpf_pkg::STATUS_DATA_PRESENT]
                     && ctrl_status[pmpf_pkg::STATUS_MOUSE_PORT];
  assign completes = is_mouse && (pos == 2'd2);
  assign push_now  = (accept && completes) || (state == S_PUSH1) || (state == S_PUSH2);

  always_comb begin
    unique case (state)
      S_PUSH1: push_byte = hold1;
      S_PUSH2: push_byte = last_byte;
      default: push_byte = hold0;
    endcase
  end

  always_comb begin
    mem.we    = push_now && !full;
    mem.waddr = wp;
    mem.wdata = push_byte;
    mem.re    = accept && (mode == pmpf_pkg::MODE_READ) && (fill != '0);
    mem.raddr = rp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rp        <= '0;
      wp        <= '0;
      fill      <= '0;
      hold0     <= '0;
      hold1     <= '0;
      pos       <= '0;
      drop_cnt  <= '0;
      res.valid <= 1'b0;
    end else begin
      if (push_now) begin
        // The first byte of a packet starts a fresh drop count.
        if (state == S_IDLE) begin
          drop_cnt <= {1'b0, full};
        end else if (full) begin
          drop_cnt <= drop_cnt + 1'b1;
        end
        if (!full) begin
          wp   <= pmpf_pkg::ptr_inc(wp);
          fill <= fill + 1'b1;
        end
      end
      unique case (state)
        S_IDLE: begin
          // A read that returns data and a completed packet report later.
          res.valid    <= accept && !mem.re && !completes;
          res.from_mem <= 1'b0;
          res.count    <= fill;
          res.dropped  <= '0;
          if (accept) begin
            if (mode == pmpf_pkg::MODE_READ) begin
              res.obyte <= '0;
              if (fill != '0) begin
                // Result waits in S_RD for the RAM read data.
                res.kind <= pmpf_pkg::KIND_READ;
                rp       <= pmpf_pkg::ptr_inc(rp);
                fill     <= fill - 1'b1;
                state    <= S_RD;
              end else begin
                res.kind <= pmpf_pkg::KIND_EMPTY;
              end
            end else if (!ctrl_status[pmpf_pkg::STATUS_DATA_PRESENT]) begin
              res.kind  <= pmpf_pkg::KIND_NO_DATA;
              res.obyte <= '0;
            end else if (!ctrl_status[pmpf_pkg::STATUS_MOUSE_PORT]) begin
              res.kind  <= pmpf_pkg::KIND_KEYBOARD;
              res.obyte <= data_byte;
            end else if ((pos == 2'd0) && !data_byte[pmpf_pkg::PKT_SYNC_BIT]) begin
              res.kind  <= pmpf_pkg::KIND_OOS_DROP;
              res.obyte <= '0;
            end else if (pos != 2'd2) begin
              if (pos == 2'd0) begin
                hold0 <= data_byte;
              end else begin
                hold1 <= data_byte;
              end
              pos       <= pos + 1'b1;
              res.kind  <= pmpf_pkg::KIND_HELD;
              res.obyte <= '0;
            end else begin
              // First byte of the packet is written this cycle.
              res.kind  <= pmpf_pkg::KIND_PUSHED;
              res.obyte <= '0;
              last_byte <= data_byte;
              pos       <= '0;
              state     <= S_PUSH1;
            end
          end
        end
        S_RD: begin
          res.valid    <= 1'b1;
          res.kind     <= pmpf_pkg::KIND_READ;
          res.from_mem <= 1'b1;
          res.obyte    <= '0;
          res.count    <= fill;
          res.dropped  <= '0;
          state        <= S_IDLE;
        end
        S_PUSH1: begin
          res.valid <= 1'b0;
          state     <= S_PUSH2;
        end
        S_PUSH2: begin
          res.valid    <= 1'b1;
          res.kind     <= pmpf_pkg::KIND_PUSHED;
          res.from_mem <= 1'b0;
          res.obyte    <= '0;
          res.count    <= full ? fill : fill + 1'b1;
          res.dropped  <= drop_cnt + {1'b0, full};
          state        <= S_IDLE;
        end
        default: begin
          res.valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= pmpf_pkg::CNT_W'(pmpf_pkg::RING_DEPTH))
    else $error("fill count exceeds ring depth");

  a_rd_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> $past(mem.re))
    else $error("read wait state entered without a RAM read");

  a_res_pulse: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> !res.valid)
    else $error("result held for more than one cycle");

  a_push_sequence: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH1) |=> (state == S_PUSH2))
    else $error("packet push sequence broken");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos != 2'd3)
    else $error("aligner position out of range");
`endif

endmodule

### sv/ps2_mouse_packet_fifo.sv
// Top level of the PS/2 mouse packet FIFO: ring RAM, control sequencer, result register.
// Depends on pmpf_pkg, pmpf_ram and pmpf_ctrl.

// Each input transaction is a PS/2 controller byte arrival (mode 0) or a request
// to read one byte from the ring (mode 1), and each gives exactly one result
// transaction. Arrivals without the data-present status bit report "no data";
// bytes from the keyboard port are forwarded in out_byte. Mouse bytes go through
// a three-byte aligner that drops a would-be first byte whose sync bit (bit 3) is
// clear; a completed packet is written to the ring one byte per cycle through the
// single RAM write port, and bytes that find the ring full are counted in
// dropped_bytes. A read returns the oldest byte, or "empty" with no state change.
// pending_count is the ring fill after the transaction. The block works on one
// transaction at a time: a read that returns data waits in S_RD for the RAM
// read data, and the byte that completes a packet goes on through S_PUSH1 and
// S_PUSH2 for its three ring writes. The result register frees the input side
// once the result has been taken or is being taken in the same cycle. The ring
// needs no clearing after reset: only written entries are ever read.
module ps2_mouse_packet_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic [7:0]                         ctrl_status,
  input  logic [7:0]                         data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         result_kind,
  output logic [7:0]                         out_byte,
  output logic [pmpf_pkg::COUNT_OUT_W-1:0]   pending_count,
  output logic [1:0]                         dropped_bytes
);

  pmpf_pkg::mem_req_t mem;
  pmpf_pkg::res_t     res;
  logic [7:0]         rd_data;
  logic               slot_free;

  // The result register can take a new result once it is empty or draining.
  assign slot_free = !out_valid || !out_stall;

  pmpf_ram #(
    .DEPTH (pmpf_pkg::RING_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rd_data)
  );

  pmpf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .mode        (mode),
    .ctrl_status (ctrl_status),
    .data_byte   (data_byte),
    .slot_free   (slot_free),
    .in_stall    (in_stall),
    .mem         (mem),
    .res         (res)
  );

  // Output register. A popped byte is picked from the RAM read data, which
  // holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      result_kind   <= res.kind;
      out_byte      <= res.from_mem ? rd_data : res.obyte;
      pending_count <= pmpf_pkg::COUNT_OUT_W'(res.count);
      dropped_bytes <= res.dropped;
    end
  end

endmodule

### bench/ps2_mouse_packet_checker.sv
// Transaction checker for the PS/2 mouse packet FIFO: watches both channels,
// predicts each result and compares it field by field. Depends on pmpf_pkg.
module ps2_mouse_packet_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             mode,
  input  logic [7:0]                       ctrl_status,
  input  logic [7:0]                       data_byte,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [2:0]                       result_kind,
  input  logic [7:0]                       out_byte,
  input  logic [pmpf_pkg::COUNT_OUT_W-1:0] pending_count,
  input  logic [1:0]                       dropped_bytes,
  output int                               fail_count,
  output int                               open_results
);
  import pmpf_pkg::*;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             obyte;
    logic [COUNT_OUT_W-1:0] count;
    logic [1:0]             dropped;
  } ps2_result_t;

  // Mirror of the block: ring contents in arrival order and the packet aligner.
  logic [7:0]  ring_bytes [$];
  logic [7:0]  held_bytes [2];
  int          packet_pos;
  ps2_result_t result_q [$];

  // Returns 1 when the byte finds the ring full and is lost.
  function automatic int store_byte(input logic [7:0] b);
    if (ring_bytes.size() >= RING_DEPTH) begin
      return 1;
    end
    ring_bytes.push_back(b);
    return 0;
  endfunction

  function automatic ps2_result_t predict_item(input logic m, input logic [7:0] st,
                                               input logic [7:0] db);
    ps2_result_t r;
    int          lost;
    r.kind  = KIND_NO_DATA;
    r.obyte = '0;
    lost    = 0;
    if (m == MODE_READ) begin
      if (ring_bytes.size() > 0) begin
        r.obyte = ring_bytes.pop_front();
        r.kind  = KIND_READ;
      end else begin
        r.kind = KIND_EMPTY;
      end
    end else if (!st[STATUS_DATA_PRESENT]) begin
      r.kind = KIND_NO_DATA;
    end else if (!st[STATUS_MOUSE_PORT]) begin
      r.obyte = db;
      r.kind  = KIND_KEYBOARD;
    end else if (packet_pos == 0 && !db[PKT_SYNC_BIT]) begin
      r.kind = KIND_OOS_DROP;
    end else if (packet_pos < 2) begin
      held_bytes[packet_pos] = db;
      packet_pos++;
      r.kind = KIND_HELD;
    end else begin
      lost = store_byte(held_bytes[0]);
      lost += store_byte(held_bytes[1]);
      lost += store_byte(db);
      packet_pos = 0;
      r.kind = KIND_PUSHED;
    end
    r.dropped = 2'(lost);
    r.count   = COUNT_OUT_W'(ring_bytes.size());
    return r;
  endfunction

  always @(posedge clk) begin
    int          errs;
    ps2_result_t want;
    errs = 0;
    if (rst) begin
      ring_bytes.delete();
      result_q.delete();
      held_bytes[0] = '0;
      held_bytes[1] = '0;
      packet_pos = 0;
      fail_count   <= 0;
      open_results <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result transaction with none outstanding: result_kind %0d", result_kind);
          errs++;
        end else begin
          want = result_q.pop_front();
          if (result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
            errs++;
          end
          if (out_byte !== want.obyte) begin
            $error("out_byte: expected %0h, got %0h", want.obyte, out_byte);
            errs++;
          end
          if (pending_count !== want.count) begin
            $error("pending_count: expected %0d, got %0d", want.count, pending_count);
            errs++;
          end
          if (dropped_bytes !== want.dropped) begin
            $error("dropped_bytes: expected %0d, got %0d", want.dropped, dropped_bytes);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        result_q.push_back(predict_item(mode, ctrl_status, data_byte));
      end
      fail_count   <= fail_count + errs;
      open_results <= result_q.size();
    end
  end

endmodule

### bench/tb_ps2_mouse_packet_fifo.sv
// Testbench top for the PS/2 mouse packet FIFO: clock, reset, stimulus, output
// stalls and the verdict. Depends on pmpf_pkg, the block and ps2_mouse_packet_checker.
module tb_ps2_mouse_packet_fifo;
  import pmpf_pkg::*;

  // Masks for the status bits and the packet sync bit.
  localparam logic [7:0] DATA_PRESENT_MASK = 8'(1 << STATUS_DATA_PRESENT);
  localparam logic [7:0] MOUSE_PORT_MASK   = 8'(1 << STATUS_MOUSE_PORT);
  localparam logic [7:0] SYNC_MASK         = 8'(1 << PKT_SYNC_BIT);
  localparam int         RANDOM_ITEMS      = 530;

  logic                   clk;
  logic                   rst         = 1'b1;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic                   mode        = MODE_ARRIVAL;
  logic [7:0]             ctrl_status = '0;
  logic [7:0]             data_byte   = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [2:0]             result_kind;
  logic [7:0]             out_byte;
  logic [COUNT_OUT_W-1:0] pending_count;
  logic [1:0]             dropped_bytes;
  int                     fail_count;
  int                     open_results;

  int sent_items    = 0;
  int sender_steady = 0;

  ps2_mouse_packet_fifo dut (.*);

  // The checker sees exactly what the block sees and tells us how many results
  // are still owed and how many comparisons went wrong.
  ps2_mouse_packet_checker packet_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Hard limit on the run. It is set several times above the slowest legal run,
  // so hitting it means the block lost or withheld a result.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [7:0] mouse_status();
    return 8'($urandom) | DATA_PRESENT_MASK | MOUSE_PORT_MASK;
  endfunction

  function automatic logic [7:0] keyboard_status();
    return (8'($urandom) | DATA_PRESENT_MASK) & ~MOUSE_PORT_MASK;
  endfunction

  // A byte that can open a packet: the sync bit is set, the rest is random.
  function automatic logic [7:0] packet_lead();
    return 8'($urandom) | SYNC_MASK;
  endfunction

  // Offers one transaction and returns at the edge where it is accepted. With
  // no gap, valid stays high and only the payload moves on to the next item.
  task automatic send_item(input logic m, input logic [7:0] st, input logic [7:0] db);
    int gap;
    if (sender_steady > 0) begin
      sender_steady--;
      gap = 0;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 99) < 3) begin
        sender_steady = $urandom_range(20, 60);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    ctrl_status <= st;
    data_byte   <= db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_mouse(input logic [7:0] db);
    send_item(MODE_ARRIVAL, mouse_status(), db);
  endtask

  task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2);
    send_mouse(b0);
    send_mouse(b1);
    send_mouse(b2);
  endtask

  // Read fields other than mode are don't-care, so they carry random values.
  task automatic read_byte();
    send_item(MODE_READ, 8'($urandom), 8'($urandom));
  endtask

  // Output side. Early on the receiver holds off for a long stretch while the
  // directed items keep coming, so the result register fills and the input
  // stalls. After that, stalls of random length alternate with free stretches,
  // some of them long enough to run with no stall at all.
  initial begin
    int len;
    @(posedge clk);
    while (rst) @(posedge clk);
    repeat (8) @(posedge clk);
    out_stall <= 1'b1;
    repeat (300) @(posedge clk);
    out_stall <= 1'b0;
    forever begin
      if ($urandom_range(0, 99) < 5) begin
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      len = gap_len();
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int r;
    int stop_at;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed part. A read of the empty ring, with all-ones fields that must
    // be ignored.
    send_item(MODE_READ, 8'hFF, 8'hFF);
    // Arrivals without the data-present bit, with every other status bit
    // clear and then set.
    send_item(MODE_ARRIVAL, 8'h00, 8'hAB);
    send_item(MODE_ARRIVAL, ~DATA_PRESENT_MASK, 8'hFF);
    // Keyboard bytes at both extremes.
    send_item(MODE_ARRIVAL, DATA_PRESENT_MASK, 8'h00);
    send_item(MODE_ARRIVAL, ~MOUSE_PORT_MASK, 8'hFF);
    // Mouse bytes that cannot open a packet are dropped while out of sync.
    send_item(MODE_ARRIVAL, DATA_PRESENT_MASK | MOUSE_PORT_MASK, ~SYNC_MASK);
    send_item(MODE_ARRIVAL, 8'hFF, 8'h00);
    // A minimal packet, then one whose later bytes lack the sync bit, with a
    // keyboard byte and an empty arrival in the middle of it.
    send_packet(SYNC_MASK, 8'h00, 8'hFF);
    send_mouse(8'hFF);
    send_item(MODE_ARRIVAL, keyboard_status(), 8'h5A);
    send_mouse(8'h00);
    send_item(MODE_ARRIVAL, 8'hFF & ~DATA_PRESENT_MASK, 8'h3C);
    send_mouse(8'h80);
    // Drain both packets and read past the end.
    repeat (7) read_byte();

    // Random part: mostly well-formed packets with random content, mixed with
    // reads, keyboard traffic, empty arrivals and stray mouse bytes that may
    // knock the aligner out of step.
    stop_at = sent_items + RANDOM_ITEMS;
    while (sent_items < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_packet(packet_lead(), 8'($urandom), 8'($urandom));
      end else if (r < 52) begin
        repeat ($urandom_range(1, 2)) send_mouse(8'($urandom));
      end else if (r < 67) begin
        repeat ($urandom_range(1, 6)) read_byte();
      end else if (r < 80) begin
        send_item(MODE_ARRIVAL, keyboard_status(), 8'($urandom));
      end else if (r < 88) begin
        send_item(MODE_ARRIVAL, 8'($urandom) & ~DATA_PRESENT_MASK, 8'($urandom));
      end else begin
        send_mouse(packet_lead());
        send_item(MODE_ARRIVAL, keyboard_status(), 8'($urandom));
        send_mouse(8'($urandom));
        read_byte();
        send_mouse(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Let the outstanding results come out, then give the block a few more
    // cycles to show any result it should not produce.
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
